### rtl/core/lsbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared types, constants and pattern tables for the status LED blink block.
// ----------------------------------------------------------------------------
package lsbp_pkg;

  // width of the millisecond elapsed counter (11 to 32)
  localparam int unsigned TimerBits = 12;
  // width wide enough for the largest interval or pause constant
  localparam int unsigned DurBits   = 11;
  localparam int unsigned ModeBits  = 3;
  localparam int unsigned TogBits   = 3;

  typedef enum logic [ModeBits-1:0] {
    MODE_OFF       = 3'd0,
    MODE_FAST      = 3'd1,
    MODE_SLOW      = 3'd2,
    MODE_DOUBLE    = 3'd3,
    MODE_TRIPLE    = 3'd4,
    MODE_STEADY_ON = 3'd5,
    MODE_ERROR     = 3'd6,
    MODE_HEARTBEAT = 3'd7
  } mode_e;

  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [DurBits-1:0]   dur_t;
  typedef logic [TogBits-1:0]   tog_t;

  // number of toggles in one flash group (twice the flash count)
  function automatic tog_t toggle_limit(mode_e m);
    tog_t r;
    unique case (m)
      MODE_FAST, MODE_SLOW, MODE_ERROR, MODE_HEARTBEAT: r = TogBits'(2);
      MODE_DOUBLE:                                      r = TogBits'(4);
      MODE_TRIPLE:                                      r = TogBits'(6);
      default:                                          r = '0;
    endcase
    return r;
  endfunction

  function automatic dur_t flash_interval(mode_e m);
    dur_t r;
    unique case (m)
      MODE_FAST:                             r = DurBits'(200);
      MODE_SLOW:                             r = DurBits'(1000);
      MODE_DOUBLE:                           r = DurBits'(150);
      MODE_TRIPLE, MODE_ERROR, MODE_HEARTBEAT: r = DurBits'(100);
      default:                               r = '0;
    endcase
    return r;
  endfunction

  function automatic dur_t pause_length(mode_e m);
    dur_t r;
    unique case (m)
      MODE_FAST:                r = DurBits'(200);
      MODE_SLOW, MODE_DOUBLE:   r = DurBits'(1000);
      MODE_TRIPLE:              r = DurBits'(1500);
      MODE_ERROR:               r = DurBits'(100);
      MODE_HEARTBEAT:           r = DurBits'(2000);
      default:                  r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/lsbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbp interfaces
// Valid/ready channels for ticks, results and the mode register write.
// ----------------------------------------------------------------------------
interface lsbp_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface lsbp_result_if;
  logic                    valid;
  logic                    ready;
  logic                    led_on;
  logic                    pausing;
  logic [lsbp_pkg::TogBits-1:0] toggle_index;

  modport source (output valid, output led_on, output pausing, output toggle_index,
                  input ready);
  modport sink   (input valid, input led_on, input pausing, input toggle_index,
                  output ready);
endinterface

interface lsbp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lsbp_pkg::ModeBits-1:0] mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

### rtl/core/led_status_blink_pattern.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_status_blink_pattern
// Status LED pattern generator driven by millisecond ticks and a mode register.
// ----------------------------------------------------------------------------
//  channel    dir  payload                            transaction
//  tick_i     in   tick                               one tick item
//  result_o   out  led_on, pausing, toggle_index      one result per tick item
//  cfg_i      in   mode                               mode register write
//
//  one tick item per cycle while result_o does not stall; its result is registered and shows in the next cycle
//  the pattern update is one increment and compare on the elapsed counter
//  result_o stalls back-pressure tick_i only while the result register is full
//  and not being taken; cfg_i is always ready
//  reset clears mode to off and all pattern state
// ----------------------------------------------------------------------------
module led_status_blink_pattern (
  input  logic            clk_i,
  input  logic            rst_ni,
  lsbp_tick_if.sink       tick_i,
  lsbp_result_if.source   result_o,
  lsbp_cfg_if.sink        cfg_i
);

  lsbp_pkg::mode_e  mode_q;
  lsbp_pkg::timer_t elapsed_q, elapsed_d;
  logic             led_q, led_d;
  lsbp_pkg::tog_t   tog_q, tog_d;
  logic             pause_q, pause_d;

  logic             out_valid_q;
  logic             lit_q, lit_d;
  logic             res_pause_q;
  lsbp_pkg::tog_t   res_tog_q;

  logic             in_take;
  logic             cfg_take;
  logic             mode_change;
  logic             flashing;
  lsbp_pkg::timer_t elapsed_inc;
  lsbp_pkg::timer_t interval_ext;
  lsbp_pkg::timer_t pause_ext;
  lsbp_pkg::tog_t   limit;

  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign cfg_i.ready  = 1'b1;

  assign in_take     = tick_i.valid && tick_i.ready;
  assign cfg_take    = cfg_i.valid;
  assign mode_change = cfg_take && (lsbp_pkg::mode_e'(cfg_i.mode) != mode_q);

  assign flashing     = (mode_q != lsbp_pkg::MODE_OFF) && (mode_q != lsbp_pkg::MODE_STEADY_ON);
  assign limit        = lsbp_pkg::toggle_limit(mode_q);
  assign interval_ext = {{(lsbp_pkg::TimerBits-lsbp_pkg::DurBits){1'b0}},
                         lsbp_pkg::flash_interval(mode_q)};
  assign pause_ext    = {{(lsbp_pkg::TimerBits-lsbp_pkg::DurBits){1'b0}},
                         lsbp_pkg::pause_length(mode_q)};
  // saturating increment
  assign elapsed_inc  = (&elapsed_q) ? elapsed_q : elapsed_q + lsbp_pkg::TimerBits'(1);

  always_comb begin
    elapsed_d = elapsed_q;
    led_d     = led_q;
    tog_d     = tog_q;
    pause_d   = pause_q;
    if (tick_i.tick && flashing) begin
      elapsed_d = elapsed_inc;
      if (pause_q) begin
        if (elapsed_inc >= pause_ext) begin
          pause_d   = 1'b0;
          tog_d     = '0;
          elapsed_d = '0;
        end
      end else if (elapsed_inc >= interval_ext) begin
        if (tog_q < limit) begin
          led_d = !led_q;
          tog_d = tog_q + lsbp_pkg::TogBits'(1);
        end else begin
          led_d   = 1'b0;
          pause_d = 1'b1;
        end
        elapsed_d = '0;
      end
    end
  end

  always_comb begin
    unique case (mode_q)
      lsbp_pkg::MODE_OFF:       lit_d = 1'b0;
      lsbp_pkg::MODE_STEADY_ON: lit_d = 1'b1;
      default:                  lit_d = led_d;
    endcase
  end

  // mode register and pattern state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lsbp_pkg::MODE_OFF;
      elapsed_q <= '0;
      led_q     <= 1'b0;
      tog_q     <= '0;
      pause_q   <= 1'b0;
    end else if (mode_change) begin
      mode_q    <= lsbp_pkg::mode_e'(cfg_i.mode);
      elapsed_q <= '0;
      led_q     <= 1'b0;
      tog_q     <= '0;
      pause_q   <= 1'b0;
    end else if (in_take) begin
      elapsed_q <= elapsed_d;
      led_q     <= led_d;
      tog_q     <= tog_d;
      pause_q   <= pause_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      lit_q       <= lit_d;
      res_pause_q <= pause_d;
      res_tog_q   <= tog_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.led_on       = lit_q;
  assign result_o.pausing      = res_pause_q;
  assign result_o.toggle_index = res_tog_q;

`ifndef ASSERT_OFF
  a_tog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tog_q <= lsbp_pkg::TogBits'(6))
    else $error("toggle count beyond largest group");

  a_pause_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pause_q |-> !led_q)
    else $error("led lit during pause");

  a_pause_full_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pause_q |-> (tog_q == limit))
    else $error("pause entered before flash group finished");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> out_valid_q)
    else $error("accepted tick produced no result");
`endif

endmodule
